// ----- rtl/lrgd_pkg.sv -----
package lrgd_pkg;

  localparam int DEF_MAX_SAMPLES = 65536;
  localparam int DEF_FRAC_BITS   = 16;

  localparam int DATA_W = 32;
  localparam int LR_W   = 24;
  localparam int SUM_W  = 64;
  localparam int LOSS_W = 48;
  localparam int CMD_W  = 2;
  localparam int CFG_W  = 2;

  localparam logic [CMD_W-1:0] CMD_TRAIN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PREDICT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELOAD  = 2'd2;

  localparam logic KIND_PRED  = 1'b0;
  localparam logic KIND_EPOCH = 1'b1;

  localparam logic [CFG_W-1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_W-1:0] REG_INIT_WEIGHT   = 2'd1;
  localparam logic [CFG_W-1:0] REG_INIT_BIAS     = 2'd2;

  localparam logic [LR_W-1:0]   RST_LEARNING_RATE = 24'd1678;
  localparam logic [DATA_W-1:0] RST_INIT_WEIGHT   = 32'd0;
  localparam logic [DATA_W-1:0] RST_INIT_BIAS     = 32'd0;

  // step magnitude cap, 2^40
  localparam logic [40:0] STEP_CAP = 41'h100_0000_0000;

  localparam logic [2:0] MUL_WX     = 3'd0;
  localparam logic [2:0] MUL_EX     = 3'd1;
  localparam logic [2:0] MUL_EE     = 3'd2;
  localparam logic [2:0] MUL_LR_LO  = 3'd3;
  localparam logic [2:0] MUL_LR_MID = 3'd4;
  localparam logic [2:0] MUL_LR_HI  = 3'd5;

  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_LD24  = 2'd1;
  localparam logic [1:0] ACC_ADD   = 2'd2;
  localparam logic [1:0] ACC_ADD32 = 2'd3;

  localparam logic [1:0] DIV_WG   = 2'd0;
  localparam logic [1:0] DIV_BG   = 2'd1;
  localparam logic [1:0] DIV_LOSS = 2'd2;

  typedef struct packed {
    logic       cap_in;
    logic       reload;
    logic       pred_en;
    logic       acc_wg;
    logic       acc_ld;
    logic       clear_epoch;
    logic [2:0] mul_sel;
    logic [1:0] acc_op;
    logic       div_start;
    logic [1:0] div_sel;
    logic       upd;
    logic       psel;
    logic       mloss_ld;
    logic       mloss_clr;
    logic       out_load;
    logic       out_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic cnt_zero;
  } dp_stat_t;

endpackage

// ----- rtl/lrgd_div.sv -----
module lrgd_div import lrgd_pkg::*; #(
  parameter int DW = SUM_W,
  parameter int NW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);

  localparam int IW = $clog2(DW + 1);

  logic [DW-1:0] q_r;
  logic [NW-1:0] rem_r;
  logic [NW-1:0] d_r;
  logic [IW-1:0] cnt_r;
  logic          busy_r;

  logic [NW:0]   shift;
  logic [NW:0]   diff;
  logic          qbit;
  logic [NW-1:0] rem_nxt;

  always_comb begin
    shift   = {rem_r, q_r[DW-1]};
    diff    = shift - {1'b0, d_r};
    qbit    = (shift >= {1'b0, d_r});
    rem_nxt = qbit ? diff[NW-1:0] : shift[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= IW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == IW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DW-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

// ----- rtl/lrgd_dpath.sv -----
module lrgd_dpath import lrgd_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctrl_cmd_t               cmd,
  output dp_stat_t                stat,
  input  logic [2*DATA_W-1:0]     in_tdata,
  input  logic                    cfg_valid,
  input  logic [CFG_W-1:0]        cfg_index,
  input  logic [DATA_W-1:0]       cfg_data,
  output logic [3*DATA_W+LOSS_W-1:0] out_tdata,
  output logic                    out_tuser
);

  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic [LR_W-1:0]          lr_r;
  logic signed [DATA_W-1:0] iw_r, ib_r;
  logic signed [DATA_W-1:0] weight_r, bias_r;
  logic signed [DATA_W-1:0] x_r, y_r, p_r;
  logic signed [DATA_W:0]   err_r;
  logic signed [65:0]       prod_r;
  logic signed [SUM_W-1:0]  wg_r, bg_r;
  logic [SUM_W-1:0]         loss_r;
  logic [CW-1:0]            cnt_r;
  logic [64:0]              acc_r;
  logic                     g_neg_r;
  logic [LOSS_W-1:0]        mloss_r;

  logic                     out_kind_r;
  logic [DATA_W-1:0]        out_pred_r, out_w_r, out_b_r;
  logic [LOSS_W-1:0]        out_loss_r;

  logic signed [DATA_W-1:0] in_x;
  logic signed [DATA_W:0]   mul_a, mul_b;
  logic signed [DATA_W:0]   nerr;
  logic [DATA_W-1:0]        aerr;
  logic [65:0]              prod_u;
  logic signed [65:0]       pshift, psum, wgc_full;
  logic signed [DATA_W-1:0] p_nxt;
  logic signed [DATA_W:0]   err_nxt;
  logic [SUM_W-1:0]         wg_nxt, bg_nxt, loss_nxt, lc, bgc;
  logic [SUM_W:0]           loss_sum;
  logic                     full;
  logic [SUM_W-1:0]         div_dividend;
  logic                     div_neg;
  logic                     div_busy;
  logic [SUM_W-1:0]         q;
  logic [40:0]              step;
  logic signed [DATA_W-1:0] base;
  logic [41:0]              upd_sum;
  logic signed [DATA_W-1:0] upd_nxt;

  function automatic logic [SUM_W-1:0] sat_add64(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add64 = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add64 = s[SUM_W-1:0];
    end
  endfunction

  assign in_x = in_tdata[DATA_W-1:0];

  // shared multiplier
  always_comb begin
    nerr = -err_r;
    aerr = err_r[DATA_W] ? nerr[DATA_W-1:0] : err_r[DATA_W-1:0];
    case (cmd.mul_sel)
      MUL_WX: begin
        mul_a = {weight_r[DATA_W-1], weight_r};
        mul_b = {in_x[DATA_W-1], in_x};
      end
      MUL_EX: begin
        mul_a = err_r;
        mul_b = {x_r[DATA_W-1], x_r};
      end
      MUL_EE: begin
        mul_a = {1'b0, aerr};
        mul_b = {1'b0, aerr};
      end
      MUL_LR_LO: begin
        mul_a = {9'b0, lr_r};
        mul_b = {9'b0, q[23:0]};
      end
      MUL_LR_MID: begin
        mul_a = {9'b0, lr_r};
        mul_b = {1'b0, q[55:24]};
      end
      MUL_LR_HI: begin
        mul_a = {9'b0, lr_r};
        mul_b = {25'b0, q[63:56]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    prod_u = prod_r;
    pshift = prod_r >>> FRAC_BITS;
    psum   = pshift + 66'(bias_r);
    if (!psum[65] && (|psum[64:31])) begin
      p_nxt = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (psum[65] && !(&psum[64:31])) begin
      p_nxt = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      p_nxt = psum[DATA_W-1:0];
    end
    err_nxt = 33'(p_nxt) - 33'(y_r);

    wgc_full = prod_r >>> (FRAC_BITS - 1);
    wg_nxt   = sat_add64(wg_r, wgc_full[SUM_W-1:0]);
    bgc      = {{30{err_r[DATA_W]}}, err_r, 1'b0};
    bg_nxt   = sat_add64(bg_r, bgc);
    lc       = 64'(prod_u >> FRAC_BITS);
    loss_sum = {1'b0, loss_r} + {1'b0, lc};
    loss_nxt = loss_sum[SUM_W] ? {SUM_W{1'b1}} : loss_sum[SUM_W-1:0];
    full     = (cnt_r == CW'(MAX_SAMPLES));
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_WG: begin
        div_neg      = wg_r[SUM_W-1];
        div_dividend = div_neg ? 64'(-wg_r) : wg_r;
      end
      DIV_BG: begin
        div_neg      = bg_r[SUM_W-1];
        div_dividend = div_neg ? 64'(-bg_r) : bg_r;
      end
      default: begin
        div_neg      = 1'b0;
        div_dividend = loss_r;
      end
    endcase
  end

  lrgd_div #(
    .DW (SUM_W),
    .NW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (cnt_r),
    .busy     (div_busy),
    .quotient (q)
  );

  // parameter step
  always_comb begin
    step    = (acc_r > 65'(STEP_CAP)) ? STEP_CAP : acc_r[40:0];
    base    = cmd.psel ? bias_r : weight_r;
    upd_sum = g_neg_r ? (42'(base) + {1'b0, step}) : (42'(base) - {1'b0, step});
    if (!upd_sum[41] && (|upd_sum[40:31])) begin
      upd_nxt = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (upd_sum[41] && !(&upd_sum[40:31])) begin
      upd_nxt = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      upd_nxt = upd_sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= RST_LEARNING_RATE;
      iw_r <= RST_INIT_WEIGHT;
      ib_r <= RST_INIT_BIAS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LEARNING_RATE: lr_r <= cfg_data[LR_W-1:0];
        REG_INIT_WEIGHT:   iw_r <= cfg_data;
        REG_INIT_BIAS:     ib_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= RST_INIT_WEIGHT;
      bias_r   <= RST_INIT_BIAS;
    end else if (cmd.reload) begin
      weight_r <= iw_r;
      bias_r   <= ib_r;
    end else if (cmd.upd) begin
      if (cmd.psel) begin
        bias_r <= upd_nxt;
      end else begin
        weight_r <= upd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wg_r   <= '0;
      bg_r   <= '0;
      loss_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.reload || cmd.clear_epoch) begin
      wg_r   <= '0;
      bg_r   <= '0;
      loss_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (cmd.acc_wg && !full) begin
        wg_r <= wg_nxt;
      end
      if (cmd.acc_ld && !full) begin
        bg_r   <= bg_nxt;
        loss_r <= loss_nxt;
        cnt_r  <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 66'(mul_a) * 66'(mul_b);
    if (cmd.cap_in) begin
      x_r <= in_tdata[DATA_W-1:0];
      y_r <= in_tdata[2*DATA_W-1:DATA_W];
    end
    if (cmd.pred_en) begin
      p_r   <= p_nxt;
      err_r <= err_nxt;
    end
    if (cmd.div_start) begin
      g_neg_r <= div_neg;
    end
    case (cmd.acc_op)
      ACC_LD24:  acc_r <= 65'(prod_u >> 24);
      ACC_ADD:   acc_r <= acc_r + prod_u[64:0];
      ACC_ADD32: acc_r <= acc_r + {prod_u[32:0], 32'b0};
      default: ;
    endcase
    if (cmd.mloss_clr) begin
      mloss_r <= '0;
    end else if (cmd.mloss_ld) begin
      mloss_r <= (|q[SUM_W-1:LOSS_W]) ? {LOSS_W{1'b1}} : q[LOSS_W-1:0];
    end
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      out_pred_r <= p_r;
      out_w_r    <= weight_r;
      out_b_r    <= bias_r;
      out_loss_r <= (cmd.out_kind == KIND_EPOCH) ? mloss_r : '0;
    end
  end

  assign stat.div_busy = div_busy;
  assign stat.cnt_zero = (cnt_r == '0);

  assign out_tdata = {out_loss_r, out_b_r, out_w_r, out_pred_r};
  assign out_tuser = out_kind_r;

endmodule

// ----- rtl/lrgd_ctrl.sv -----
module lrgd_ctrl import lrgd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [CMD_W-1:0] in_tuser,
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  dp_stat_t         stat,
  output ctrl_cmd_t        cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PRED = 4'd1;
  localparam logic [3:0] S_EX   = 4'd2;
  localparam logic [3:0] S_EE   = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_DIVW = 4'd6;
  localparam logic [3:0] S_D0   = 4'd7;
  localparam logic [3:0] S_D1   = 4'd8;
  localparam logic [3:0] S_D2   = 4'd9;
  localparam logic [3:0] S_D3   = 4'd10;
  localparam logic [3:0] S_D4   = 4'd11;
  localparam logic [3:0] S_DIVL = 4'd12;
  localparam logic [3:0] S_EMIT = 4'd13;

  logic [3:0]       state_r, state_nxt;
  logic [CMD_W-1:0] op_r, op_nxt;
  logic             last_r, last_nxt;
  logic             psel_r, psel_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic             accept;
  logic             out_free;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    last_nxt  = last_r;
    psel_nxt  = psel_r;
    cmd       = '0;
    cmd.mul_sel  = MUL_WX;
    cmd.acc_op   = ACC_NONE;
    cmd.div_sel  = DIV_WG;
    cmd.psel     = psel_r;
    cmd.out_kind = (op_r == CMD_TRAIN) ? KIND_EPOCH : KIND_PRED;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.cap_in = 1'b1;
          op_nxt     = in_tuser;
          last_nxt   = in_tlast;
          case (in_tuser)
            CMD_RELOAD:  cmd.reload = 1'b1;
            CMD_TRAIN:   state_nxt  = S_PRED;
            CMD_PREDICT: state_nxt  = S_PRED;
            default: ;
          endcase
        end
      end
      S_PRED: begin
        cmd.pred_en = 1'b1;
        state_nxt   = (op_r == CMD_PREDICT) ? S_EMIT : S_EX;
      end
      S_EX: begin
        cmd.mul_sel = MUL_EX;
        state_nxt   = S_EE;
      end
      S_EE: begin
        cmd.mul_sel = MUL_EE;
        cmd.acc_wg  = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.acc_ld = 1'b1;
        state_nxt  = last_r ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        if (stat.cnt_zero) begin
          cmd.mloss_clr = 1'b1;
          state_nxt     = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_WG;
          psel_nxt      = 1'b0;
          state_nxt     = S_DIVW;
        end
      end
      S_DIVW: begin
        if (!stat.div_busy) begin
          state_nxt = S_D0;
        end
      end
      S_D0: begin
        cmd.mul_sel = MUL_LR_LO;
        state_nxt   = S_D1;
      end
      S_D1: begin
        cmd.mul_sel = MUL_LR_MID;
        cmd.acc_op  = ACC_LD24;
        state_nxt   = S_D2;
      end
      S_D2: begin
        cmd.mul_sel = MUL_LR_HI;
        cmd.acc_op  = ACC_ADD;
        state_nxt   = S_D3;
      end
      S_D3: begin
        cmd.acc_op = ACC_ADD32;
        state_nxt  = S_D4;
      end
      S_D4: begin
        cmd.upd       = 1'b1;
        cmd.div_start = 1'b1;
        if (psel_r) begin
          cmd.div_sel = DIV_LOSS;
          state_nxt   = S_DIVL;
        end else begin
          cmd.div_sel = DIV_BG;
          psel_nxt    = 1'b1;
          state_nxt   = S_DIVW;
        end
      end
      S_DIVL: begin
        if (!stat.div_busy) begin
          cmd.mloss_ld = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.out_load    = 1'b1;
          cmd.clear_epoch = (op_r == CMD_TRAIN);
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= CMD_TRAIN;
      last_r       <= 1'b0;
      psel_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      last_r       <= last_nxt;
      psel_r       <= psel_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

// ----- rtl/linear_regression_gd_trainer.sv -----
// Predict: product, prediction and output registered in turn; next item taken once loaded.
// Train sample without end mark: paced by the shared 33x33 multiplier used three times in
// turn (w*x, err*x, err*err). End of epoch: paced by three 64-step shift-subtract divisions
// on one shared divider plus two step updates (states D0 to D4). Reload: weight and bias
// from initial values. Output registered; a stall holds input.
// Reset (rst_n, synchronous): sums and count cleared, weight and bias 0, rate 1678.
module linear_regression_gd_trainer import lrgd_pkg::*; #(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [2*DATA_W-1:0]        in_tdata,   // sample_x, target_y
  input  logic [CMD_W-1:0]           in_tuser,   // command
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [3*DATA_W+LOSS_W-1:0] out_tdata,  // predicted_y, weight_now, bias_now, mean_loss
  output logic                       out_tuser,  // kind
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_W-1:0]           cfg_index,
  input  logic [DATA_W-1:0]          cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  lrgd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  lrgd_dpath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
